// ===== rtl/core/cfcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcr_pkg
// Shared types, codes and the byte-wide CRC-16/MODBUS update for the framed
// command receiver.
// ----------------------------------------------------------------------------
package cfcr_pkg;

    localparam logic [7:0]  HDR_FIRST  = 8'hAA;
    localparam logic [7:0]  HDR_SECOND = 8'h55;
    localparam logic [7:0]  FN_ENABLE  = 8'h01;
    localparam logic [7:0]  FN_DISABLE = 8'h02;
    localparam logic [7:0]  FN_QUERY   = 8'h03;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    localparam logic [7:0] RST_DEVICE_ADDRESS = 8'd1;
    localparam logic [7:0] RST_WARN_THRESHOLD = 8'd50;
    localparam logic [7:0] RST_REPORT_PERIOD  = 8'd50;
    localparam logic [7:0] RST_MAX_PAYLOAD    = 8'd32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        REG_DEVICE_ADDRESS = 2'd0,
        REG_WARN_THRESHOLD = 2'd1,
        REG_REPORT_PERIOD  = 2'd2,
        REG_MAX_PAYLOAD    = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_ACCEPT     = 3'd1,
        EV_CRC_ERR    = 3'd2,
        EV_LEN_ERR    = 3'd3,
        EV_OTHER_ADDR = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_ENABLE  = 2'd1,
        ACT_DISABLE = 2'd2,
        ACT_QUERY   = 2'd3
    } t_action;

    typedef struct packed {
        logic [7:0] device_address;
        logic [7:0] warn_threshold;
        logic [7:0] report_period;
        logic [7:0] max_payload;
    } t_cfg;

    typedef struct packed {
        logic       is_tick;
        t_event     event_code;
        t_action    action;
        logic [7:0] sensor;
    } t_cmd;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/cfcr_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcr_in_if
// Input channel: one received byte or one timer tick per item.
// ----------------------------------------------------------------------------
interface cfcr_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;
    logic [7:0] sensor_value;

    modport source (output valid, output command, output rx_byte, output sensor_value,
                    input ready);
    modport sink   (input valid, input command, input rx_byte, input sensor_value,
                    output ready);
endinterface

// ===== rtl/core/cfcr_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcr_out_if
// Result channel: frame event, status reply and indicator state per item.
// ----------------------------------------------------------------------------
interface cfcr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] frame_event;
    logic       reply_valid;
    logic       reply_enable;
    logic [7:0] reply_sensor;
    logic       monitor_on;
    logic       warn_led;
    logic       ok_led;

    modport source (output valid, output frame_event, output reply_valid,
                    output reply_enable, output reply_sensor, output monitor_on,
                    output warn_led, output ok_led, input ready);
    modport sink   (input valid, input frame_event, input reply_valid,
                    input reply_enable, input reply_sensor, input monitor_on,
                    input warn_led, input ok_led, output ready);
endinterface

// ===== rtl/core/crc_framed_command_receiver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_framed_command_receiver_unit
// Byte-wise frame receiver with CRC-16/MODBUS check and light monitoring.
//
// i_in carries one item per handshake: a received serial byte (command 0)
// or a timer tick (command 1), each with a sensor sample. o_out returns
// exactly one result item per input item, in order: frame event, optional
// status reply, monitor flag and both indicator outputs.
// The parser classifies each item in the cycle it is accepted and writes it
// into a two-entry queue; the executor takes the queue head into the output
// register whenever that register is empty or being taken by o_out, and the
// result is valid from there. With its byte-wide CRC update the block takes
// one item per cycle, as does the executor, while o_out is not stalled.
// When o_out is stalled the output register holds, the queue fills, and
// i_in.ready drops only once both queue entries are taken.
// Reset clears the parser to header hunt, the monitor flag, tick count and
// indicators, and loads the register defaults; there is no clearing pass.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data.
// ----------------------------------------------------------------------------
module crc_framed_command_receiver_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    cfcr_in_if.sink    i_in,
    cfcr_out_if.source o_out
);
    import cfcr_pkg::*;

    t_cfg r_cfg;
    logic q_ready, q_push, q_valid, q_pop;
    t_cmd front_cmd, head_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= RST_DEVICE_ADDRESS;
            r_cfg.warn_threshold <= RST_WARN_THRESHOLD;
            r_cfg.report_period  <= RST_REPORT_PERIOD;
            r_cfg.max_payload    <= RST_MAX_PAYLOAD;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_DEVICE_ADDRESS: r_cfg.device_address <= i_cfg_data;
                REG_WARN_THRESHOLD: r_cfg.warn_threshold <= i_cfg_data;
                REG_REPORT_PERIOD:  r_cfg.report_period  <= i_cfg_data;
                REG_MAX_PAYLOAD:    r_cfg.max_payload    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cfcr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (q_push),
        .o_cmd     (front_cmd)
    );

    cfcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    cfcr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );
endmodule

// ===== rtl/core/cfcr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcr_front
// Frame parser: hunts for the header, runs the CRC byte by byte and turns
// each item into a classified command for the back end.
// ----------------------------------------------------------------------------
module cfcr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cfcr_pkg::t_cfg   i_cfg,
    cfcr_in_if.sink          i_in,
    input  logic             i_q_ready,
    output logic             o_push,
    output cfcr_pkg::t_cmd   o_cmd
);
    import cfcr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT, PH_HDR2, PH_ADDR, PH_FUNC, PH_LEN, PH_DATA, PH_CRCLO, PH_CRCHI
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_remain, n_remain;
    logic [7:0]  r_addr, n_addr;
    logic [7:0]  r_func, n_func;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic [7:0]  b;
    logic [7:0]  remain_dec;

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;
    assign b          = i_in.rx_byte;
    assign remain_dec = r_remain - 8'd1;

    always_comb begin
        n_phase  = r_phase;
        n_remain = r_remain;
        n_addr   = r_addr;
        n_func   = r_func;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        o_cmd.is_tick    = i_in.command;
        o_cmd.event_code = EV_NONE;
        o_cmd.action     = ACT_NONE;
        o_cmd.sensor     = i_in.sensor_value;
        if (!i_in.command) begin
            case (r_phase)
                PH_HUNT: begin
                    if (b == HDR_FIRST) n_phase = PH_HDR2;
                end
                PH_HDR2: begin
                    if (b == HDR_SECOND) begin
                        n_crc   = crc_feed(crc_feed(CRC_INIT, HDR_FIRST), HDR_SECOND);
                        n_phase = PH_ADDR;
                    end else if (b != HDR_FIRST) begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_ADDR: begin
                    n_addr  = b;
                    n_crc   = crc_feed(r_crc, b);
                    n_phase = PH_FUNC;
                end
                PH_FUNC: begin
                    n_func  = b;
                    n_crc   = crc_feed(r_crc, b);
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    if (b > i_cfg.max_payload) begin
                        o_cmd.event_code = EV_LEN_ERR;
                        n_phase          = PH_HUNT;
                    end else begin
                        n_crc    = crc_feed(r_crc, b);
                        n_remain = b;
                        n_phase  = (b == 8'd0) ? PH_CRCLO : PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_crc    = crc_feed(r_crc, b);
                    n_remain = remain_dec;
                    if (remain_dec == 8'd0) n_phase = PH_CRCLO;
                end
                PH_CRCLO: begin
                    n_crc_lo = b;
                    n_phase  = PH_CRCHI;
                end
                PH_CRCHI: begin
                    n_phase = PH_HUNT;
                    if ({b, r_crc_lo} != r_crc) begin
                        o_cmd.event_code = EV_CRC_ERR;
                    end else if (r_addr != i_cfg.device_address) begin
                        o_cmd.event_code = EV_OTHER_ADDR;
                    end else begin
                        o_cmd.event_code = EV_ACCEPT;
                        if (r_func == FN_ENABLE)       o_cmd.action = ACT_ENABLE;
                        else if (r_func == FN_DISABLE) o_cmd.action = ACT_DISABLE;
                        else if (r_func == FN_QUERY)   o_cmd.action = ACT_QUERY;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_remain <= 8'd0;
            r_addr   <= 8'd0;
            r_func   <= 8'd0;
            r_crc    <= CRC_INIT;
            r_crc_lo <= 8'd0;
        end else if (o_push) begin
            r_phase  <= n_phase;
            r_remain <= n_remain;
            r_addr   <= n_addr;
            r_func   <= n_func;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end
endmodule

// ===== rtl/core/cfcr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcr_queue
// Small command queue between the parser and the executor.
// ----------------------------------------------------------------------------
module cfcr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cfcr_pkg::t_cmd i_cmd,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output cfcr_pkg::t_cmd o_cmd
);
    import cfcr_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    assign o_ready = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                          : r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                          : r_rd_ptr + QUEUE_AW'(1);
            end
            if (i_push && !i_pop)      r_count <= r_count + QUEUE_CW'(1);
            else if (!i_push && i_pop) r_count <= r_count - QUEUE_CW'(1);
        end
    end
endmodule

// ===== rtl/core/cfcr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcr_back
// Command executor: monitor flag, tick counter, indicators and the output
// register of the result channel.
// ----------------------------------------------------------------------------
module cfcr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cfcr_pkg::t_cfg i_cfg,
    input  logic           i_q_valid,
    input  cfcr_pkg::t_cmd i_cmd,
    output logic           o_pop,
    cfcr_out_if.source     o_out
);
    import cfcr_pkg::*;

    logic       r_valid;
    logic [2:0] r_event, n_event;
    logic       r_reply, n_reply;
    logic       r_reply_en, n_reply_en;
    logic [7:0] r_reply_sens, n_reply_sens;
    logic       r_monitor, n_monitor;
    logic [1:0] r_leds, n_leds;
    logic [7:0] r_ticks, n_ticks;
    logic [7:0] tick_inc;

    assign o_pop    = i_q_valid && (!r_valid || o_out.ready);
    assign tick_inc = r_ticks + 8'd1;

    always_comb begin
        n_event      = i_cmd.event_code;
        n_reply      = 1'b0;
        n_reply_en   = 1'b0;
        n_reply_sens = 8'd0;
        n_monitor    = r_monitor;
        n_leds       = r_leds;
        n_ticks      = r_ticks;
        if (i_cmd.is_tick) begin
            if (r_monitor) begin
                if (tick_inc >= i_cfg.report_period) begin
                    n_ticks      = 8'd0;
                    n_reply      = 1'b1;
                    n_reply_en   = 1'b1;
                    n_reply_sens = i_cmd.sensor;
                    n_leds       = (i_cmd.sensor < i_cfg.warn_threshold) ? 2'b01 : 2'b10;
                end else begin
                    n_ticks = tick_inc;
                end
            end
        end else if (i_cmd.event_code == EV_ACCEPT) begin
            case (i_cmd.action)
                ACT_ENABLE: n_monitor = 1'b1;
                ACT_DISABLE: begin
                    n_monitor = 1'b0;
                    n_leds    = 2'b00;
                end
                ACT_QUERY: begin
                    n_reply      = 1'b1;
                    n_reply_en   = r_monitor;
                    n_reply_sens = i_cmd.sensor;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_monitor <= 1'b0;
            r_leds    <= 2'b00;
            r_ticks   <= 8'd0;
        end else begin
            if (o_pop) begin
                r_valid   <= 1'b1;
                r_monitor <= n_monitor;
                r_leds    <= n_leds;
                r_ticks   <= n_ticks;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_event      <= n_event;
            r_reply      <= n_reply;
            r_reply_en   <= n_reply_en;
            r_reply_sens <= n_reply_sens;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.frame_event  = r_event;
    assign o_out.reply_valid  = r_reply;
    assign o_out.reply_enable = r_reply_en;
    assign o_out.reply_sensor = r_reply_sens;
    assign o_out.monitor_on   = r_monitor;
    assign o_out.warn_led     = r_leds[0];
    assign o_out.ok_led       = r_leds[1];
endmodule
